// ===== hw/rtl/hns_pkg.sv =====
// Shared types and constants for the integer hypotenuse core.
// Holds the controller/datapath command and status bundles; no dependencies.
package hns_pkg;

    localparam int LEN_W = 16;

    typedef struct packed {
        logic load;        // capture component magnitudes
        logic square;      // register both squares
        logic sum;         // form val
        logic guess_val;   // start guess = val
        logic div_start;   // launch the shared divider
        logic div_diff;    // divisor is |mx-my| rather than the guess
        logic take_q;      // start guess = quotient
        logic newton;      // guess = (val/guess + guess) / 2
        logic res_load;    // capture result
        logic res_zero;    // result is zero instead of the guess
        logic out_load;    // move result into the output register
    } t_cmd;

    typedef struct packed {
        logic val_zero;
        logic mag_eq;
        logic div_done;
        logic quo_zero;
        logic stop;        // Newton step did not shrink the guess, or hit one or zero
    } t_sts;

endpackage

// ===== hw/rtl/hns_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Used by hns_dpath for every division of the Newton loop; no package use.
module hns_div #(
    parameter int VAL_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [VAL_W-1:0] i_num,
    input  logic [VAL_W-1:0] i_den,
    output logic             o_done,
    output logic [VAL_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(VAL_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [VAL_W:0]   r_rem;
    logic [VAL_W-1:0] r_quo;
    logic [VAL_W-1:0] r_den;

    logic [VAL_W:0]   n_shift;
    logic [VAL_W:0]   n_diff;
    logic             n_fit;

    always_comb begin
        n_shift = {r_rem[VAL_W-1:0], r_quo[VAL_W-1]};
        n_diff  = n_shift - {1'b0, r_den};
        n_fit   = (n_shift >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VAL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_fit ? n_diff : n_shift;
            r_quo <= {r_quo[VAL_W-2:0], n_fit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== hw/rtl/hns_dpath.sv =====
// Datapath: magnitudes, squares, sum, guess registers and Newton update.
// Depends on hns_pkg for command/status types and on hns_div.
module hns_dpath #(
    parameter int COMP_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hns_pkg::t_cmd                i_cmd,
    input  logic signed [COMP_WIDTH-1:0] i_comp_x,
    input  logic signed [COMP_WIDTH-1:0] i_comp_y,
    output hns_pkg::t_sts                o_sts,
    output logic [hns_pkg::LEN_W-1:0]    o_length
);

    import hns_pkg::*;

    localparam int VAL_W = 2 * COMP_WIDTH;

    logic [COMP_WIDTH-1:0] r_mx;
    logic [COMP_WIDTH-1:0] r_my;
    logic [VAL_W-1:0]      r_sqx;
    logic [VAL_W-1:0]      r_sqy;
    logic [VAL_W-1:0]      r_val;
    logic [VAL_W-1:0]      r_guess;
    logic [LEN_W-1:0]      r_res;
    logic [LEN_W-1:0]      r_length;

    logic [COMP_WIDTH-1:0] n_mx;
    logic [COMP_WIDTH-1:0] n_my;
    logic [COMP_WIDTH-1:0] n_diff;
    logic [VAL_W-1:0]      n_den;
    logic [VAL_W:0]        n_sum;
    logic [VAL_W-1:0]      n_guess;
    logic                  div_done;
    logic [VAL_W-1:0]      div_quo;

    // Most negative input negates to 2^(W-1), exact as unsigned
    assign n_mx = i_comp_x[COMP_WIDTH-1] ? (~i_comp_x + 1'b1) : i_comp_x;
    assign n_my = i_comp_y[COMP_WIDTH-1] ? (~i_comp_y + 1'b1) : i_comp_y;

    assign n_diff  = (r_mx > r_my) ? (r_mx - r_my) : (r_my - r_mx);
    assign n_den   = i_cmd.div_diff ? VAL_W'(n_diff) : r_guess;
    assign n_sum   = {1'b0, div_quo} + {1'b0, r_guess};
    assign n_guess = n_sum[VAL_W:1];

    hns_div #(
        .VAL_W (VAL_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_val),
        .i_den   (n_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mx <= n_mx;
            r_my <= n_my;
        end
        if (i_cmd.square) begin
            r_sqx <= r_mx * r_mx;
            r_sqy <= r_my * r_my;
        end
        if (i_cmd.sum) begin
            r_val <= r_sqx + r_sqy;
        end
        if (i_cmd.guess_val) begin
            r_guess <= r_val;
        end else if (i_cmd.take_q) begin
            r_guess <= div_quo;
        end else if (i_cmd.newton) begin
            r_guess <= n_guess;
        end
        if (i_cmd.res_load) begin
            r_res <= i_cmd.res_zero ? '0 : LEN_W'(r_guess);
        end
        if (i_cmd.out_load) begin
            r_length <= r_res;
        end
    end

    always_comb begin
        o_sts.val_zero = (r_val == '0);
        o_sts.mag_eq   = (r_mx == r_my);
        o_sts.div_done = div_done;
        o_sts.quo_zero = (div_quo == '0);
        o_sts.stop     = (n_guess == VAL_W'(1)) || (n_guess >= r_guess)
                         || (n_guess == '0);
    end

    assign o_length = r_length;

endmodule

// ===== hw/rtl/hns_ctrl.sv =====
// Controller: sequences load, square, sum, start division and Newton steps.
// Depends on hns_pkg for command/status types; drives hns_dpath.
module hns_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  hns_pkg::t_sts i_sts,
    output hns_pkg::t_cmd o_cmd
);

    import hns_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQR  = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_DIV0 = 3'd4;
    localparam logic [2:0] ST_STEP = 3'd5;
    localparam logic [2:0] ST_DIVN = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SQR;
                end
            end
            ST_SQR: begin
                o_cmd.square = 1'b1;
                n_state      = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_CHK;
            end
            ST_CHK: begin
                if (i_sts.val_zero) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_zero = 1'b1;
                    n_state        = ST_DONE;
                end else if (i_sts.mag_eq) begin
                    o_cmd.guess_val = 1'b1;
                    n_state         = ST_STEP;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_diff  = 1'b1;
                    n_state         = ST_DIV0;
                end
            end
            ST_DIV0: begin
                if (i_sts.div_done) begin
                    if (i_sts.quo_zero) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_zero = 1'b1;
                        n_state        = ST_DONE;
                    end else begin
                        o_cmd.take_q = 1'b1;
                        n_state      = ST_STEP;
                    end
                end
            end
            ST_STEP: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIVN;
            end
            ST_DIVN: begin
                if (i_sts.div_done) begin
                    // return the guess from before a step that failed to shrink or reached one or zero
                    if (i_sts.stop) begin
                        o_cmd.res_load = 1'b1;
                        n_state        = ST_DONE;
                    end else begin
                        o_cmd.newton = 1'b1;
                        n_state      = ST_STEP;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/hypotenuse_newton_sqrt_core.sv =====
// Integer hypotenuse core: length = Newton square root of x^2 + y^2.
// Runs one division for the start guess and one per Newton step taken
// (no start division when |x| equals |y|); each division runs one quotient
// bit per cycle on the single shared divider. One word in flight at a time.
// Synchronous active-low reset clears the controller and output valid.
// Depends on hns_pkg, hns_ctrl, hns_dpath and hns_div.
module hypotenuse_newton_sqrt_core #(
    parameter int COMP_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [COMP_WIDTH-1:0] i_comp_x,
    input  logic signed [COMP_WIDTH-1:0] i_comp_y,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [hns_pkg::LEN_W-1:0]    o_length
);

    import hns_pkg::*;

    t_cmd cmd;
    t_sts sts;

    hns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    hns_dpath #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_comp_x (i_comp_x),
        .i_comp_y (i_comp_y),
        .o_sts    (sts),
        .o_length (o_length)
    );

endmodule
